### rtl/bsoi_pkg.sv
`timescale 1ns / 1ps

package bsoi_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 7;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_ORD   = 3'd2,
        OP_POS   = 3'd3,
        OP_DEL   = 3'd4,
        OP_CLEAR = 3'd5
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CM_HOLD,
        CM_INS,
        CM_DEL,
        CM_POP
    } cell_mode_t;

    typedef enum logic [1:0] {
        IK_TOP,
        IK_ORD,
        IK_POS
    } ins_kind_t;

    typedef struct packed {
        cell_mode_t mode;
        ins_kind_t  kind;
    } cell_cmd_t;

endpackage

### rtl/bsoi_cell.sv
`timescale 1ns / 1ps

module bsoi_cell
    import bsoi_pkg::*;
#(
    parameter int IDX   = 0,
    parameter int CNT_W = 7,
    parameter int CMP_W = 14
) (
    input  logic                    aclk,
    input  cell_cmd_t               cmd,
    input  logic signed [VAL_W-1:0] value,
    input  logic        [POS_W-1:0] position,
    input  logic        [CNT_W-1:0] count,
    input  logic signed [VAL_W-1:0] above_data,
    input  logic signed [VAL_W-1:0] below_data,
    input  logic                    found_in,
    output logic                    found_out,
    output logic signed [VAL_W-1:0] data,
    output logic signed [VAL_W-1:0] data_next
);

    localparam logic IS_TOP = (IDX == 0);

    logic signed [VAL_W-1:0] data_reg;
    logic                    live;
    logic                    hit_ins;
    logic                    hit;

    always_comb begin
        live = CMP_W'(count) > CMP_W'(IDX);
        case (cmd.kind)
            IK_TOP:  hit_ins = IS_TOP;
            IK_ORD:  hit_ins = !live || !(data_reg < value);
            IK_POS:  hit_ins = CMP_W'(position) == CMP_W'(IDX + 1);
            default: hit_ins = 1'b0;
        endcase
        case (cmd.mode)
            CM_INS:  hit = hit_ins;
            CM_DEL:  hit = live && (data_reg == value);
            default: hit = 1'b0;
        endcase
        found_out = found_in | hit;
        case (cmd.mode)
            CM_INS: begin
                if (found_in) begin
                    data_next = above_data;
                end else if (hit) begin
                    data_next = value;
                end else begin
                    data_next = data_reg;
                end
            end
            CM_DEL: begin
                data_next = (found_in || hit) ? below_data : data_reg;
            end
            CM_POP:  data_next = below_data;
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

### rtl/bounded_stack_with_ordered_insert.sv
`timescale 1ns / 1ps

// A bounded stack of signed 32-bit values kept in a row of DEPTH cells, the
// top entry in the first cell. Every request (push, pop, ordered insert,
// insert at a position from the top, delete the first match from the top,
// clear) is carried out by the whole cell row in the cycle in which the item
// is accepted, so the block takes one item per clock; its result appears in
// the output register on the next cycle and is held there while the result
// side stalls, with a new item still accepted as the result is taken. The
// request code travels in s_axis_tuser and top_valid in m_axis_tuser.
// Failed requests (full, bad position, empty pop, no match) leave the stack
// unchanged and only report their status.
module bounded_stack_with_ordered_insert
    import bsoi_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ST_W + CNT_W + 2 * VAL_W,
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [39:0]          s_axis_tdata,  // value, position, zero fill
    input  logic [OP_W-1:0]      s_axis_tuser,  // op
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // status, count, top_value,
                                                // removed_value, zero fill
    output logic                 m_axis_tuser   // top_valid
);

    localparam int CMP_W = CNT_W + POS_W;

    logic signed [VAL_W-1:0] in_value;
    logic        [POS_W-1:0] in_pos;
    logic                    accept;

    logic        [CNT_W-1:0] count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    status_t                 status_reg, status_next;
    logic        [CNT_W-1:0] cnt_out_reg;
    logic                    top_valid_reg;
    logic signed [VAL_W-1:0] top_value_reg, top_value_next;
    logic signed [VAL_W-1:0] removed_reg, removed_next;

    cell_cmd_t               cmd;
    logic                    full;
    logic                    bad_pos;

    logic signed [VAL_W-1:0] cell_data [DEPTH];
    logic signed [VAL_W-1:0] cell_next [DEPTH];
    logic                    found [DEPTH+1];

    assign in_value      = s_axis_tdata[VAL_W-1:0];
    assign in_pos        = s_axis_tdata[VAL_W+POS_W-1:VAL_W];
    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign found[0]      = 1'b0;

    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic signed [VAL_W-1:0] above_d;
        logic signed [VAL_W-1:0] below_d;
        if (k == 0) begin : g_first
            assign above_d = in_value;
        end else begin : g_mid
            assign above_d = cell_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign below_d = '0;
        end else begin : g_more
            assign below_d = cell_data[k+1];
        end
        bsoi_cell #(
            .IDX   (k),
            .CNT_W (CNT_W),
            .CMP_W (CMP_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .value      (in_value),
            .position   (in_pos),
            .count      (count_reg),
            .above_data (above_d),
            .below_data (below_d),
            .found_in   (found[k]),
            .found_out  (found[k+1]),
            .data       (cell_data[k]),
            .data_next  (cell_next[k])
        );
    end

    always_comb begin
        full    = count_reg == CNT_W'(DEPTH);
        bad_pos = (in_pos == '0) ||
                  (CMP_W'(in_pos) > CMP_W'(count_reg) + CMP_W'(1));
        cmd.mode = CM_HOLD;
        cmd.kind = IK_TOP;
        case (op_t'(s_axis_tuser))
            OP_PUSH, OP_ORD, OP_POS: begin
                cmd.kind = (op_t'(s_axis_tuser) == OP_ORD) ? IK_ORD :
                           (op_t'(s_axis_tuser) == OP_POS) ? IK_POS : IK_TOP;
                if (!full && !(op_t'(s_axis_tuser) == OP_POS && bad_pos)) begin
                    cmd.mode = CM_INS;
                end
            end
            OP_POP: begin
                if (count_reg != '0) begin
                    cmd.mode = CM_POP;
                end
            end
            OP_DEL:  cmd.mode = CM_DEL;
            default: cmd.mode = CM_HOLD;
        endcase
        if (!accept) begin
            cmd.mode = CM_HOLD;
        end
    end

    always_comb begin
        status_next  = ST_OK;
        count_next   = count_reg;
        removed_next = '0;
        case (op_t'(s_axis_tuser))
            OP_PUSH, OP_ORD, OP_POS: begin
                if (full) begin
                    status_next = ST_FULL;
                end else if (op_t'(s_axis_tuser) == OP_POS && bad_pos) begin
                    status_next = ST_BADPOS;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            OP_POP: begin
                if (count_reg == '0) begin
                    status_next = ST_EMPTY;
                end else begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = cell_data[0];
                end
            end
            OP_DEL: begin
                if (found[DEPTH]) begin
                    count_next   = count_reg - CNT_W'(1);
                    removed_next = in_value;
                end else begin
                    status_next = ST_NOTFOUND;
                end
            end
            OP_CLEAR: count_next = '0;
            default:  count_next = count_reg;
        endcase
        if (!accept) begin
            count_next = count_reg;
        end
        top_value_next = (count_next != '0) ? cell_next[0] : '0;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg    <= status_next;
            cnt_out_reg   <= count_next;
            top_valid_reg <= count_next != '0;
            top_value_reg <= top_value_next;
            removed_reg   <= removed_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = top_valid_reg;
    assign m_axis_tdata[ST_W-1:0]                    = status_reg;
    assign m_axis_tdata[ST_W+CNT_W-1:ST_W]           = cnt_out_reg;
    assign m_axis_tdata[ST_W+CNT_W+VAL_W-1:ST_W+CNT_W] = top_value_reg;
    assign m_axis_tdata[OUT_W-1:ST_W+CNT_W+VAL_W]    = removed_reg;

    if (M_TDATA_W > OUT_W) begin : g_pad
        assign m_axis_tdata[M_TDATA_W-1:OUT_W] = '0;
    end

endmodule
